FILE: design/vsrsc_pkg.sv
package vsrsc_pkg;

  // Operation codes on the input stream
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TX_START   = 3'd0;
  localparam logic [2:0] REG_TX_END     = 3'd1;
  localparam logic [2:0] REG_TX_FORWARD = 3'd2;
  localparam logic [2:0] REG_CDS_START  = 3'd3;
  localparam logic [2:0] REG_CDS_END    = 3'd4;
  localparam logic [2:0] REG_EXON_COUNT = 3'd5;
  localparam logic [2:0] REG_SPL_EXONIC = 3'd6;
  localparam logic [2:0] REG_SPL_INTRON = 3'd7;

  // Signed edge arithmetic width
  localparam int unsigned EW = 34;
  typedef logic signed [EW-1:0] edge_t;

  // Input request fields, highest bit first
  typedef struct packed {
    logic [31:0] span_end;
    logic [31:0] span_start;
    logic [31:0] exon_last;
    logic [31:0] exon_first;
    logic [5:0]  exon_index;
  } in_data_t;

  // Widen an unsigned 32-bit coordinate into edge arithmetic
  function automatic edge_t to_edge(input logic [31:0] v);
    return edge_t'({2'b00, v});
  endfunction

  // Closed interval overlap of [s,e] with [lo,hi]
  function automatic logic ovl(input edge_t s, input edge_t e,
                               input edge_t lo, input edge_t hi);
    return (hi >= lo) && (e >= lo) && (s <= hi);
  endfunction

endpackage

FILE: design/variant_span_region_splice_classifier.sv
// Timing: a load is written at its accepting edge; a classify makes an exon pass, then a gap
// pass over the N exons in use (both skipped with none), one exon table read per cycle.
// Flow: one request at a time; a classify holds the input until its result is registered,
// a load does not; a waiting result holds the next one in its last step.
// Reset: synchronous active-high rst restores the config registers to defaults, idles the
// sequencer and empties the output; the exon table is not cleared and is undefined until loaded.
module variant_span_region_splice_classifier #(
  parameter int unsigned MAX_EXONS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: exon_index[5:0], exon_first, exon_last, span_start, span_end, zero pad
  input  logic [135:0] s_tdata,
  // tuser: operation, is_insertion
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: region_bits[6:0], feature_flags[14:7], splice_flags[22:15], zero pad
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vsrsc_pkg::*;

  localparam int unsigned AW = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXONS + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXON, S_GAP, S_FIN} state_t;

  // Configuration registers
  logic [31:0] tx_start, tx_end, cds_start, cds_end;
  logic        tx_forward;
  logic [6:0]  exon_total;
  logic [7:0]  exon_reach, intron_reach;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_start <= '0; tx_end <= '0; tx_forward <= 1'b1;
      cds_start <= '0; cds_end <= '0; exon_total <= '0;
      exon_reach <= 8'd3; intron_reach <= 8'd8;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_TX_START:   tx_start <= pwdata;
        REG_TX_END:     tx_end <= pwdata;
        REG_TX_FORWARD: tx_forward <= pwdata[0];
        REG_CDS_START:  cds_start <= pwdata;
        REG_CDS_END:    cds_end <= pwdata;
        REG_EXON_COUNT: exon_total <= pwdata[6:0];
        REG_SPL_EXONIC: exon_reach <= pwdata[7:0];
        REG_SPL_INTRON: intron_reach <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TX_START:   prdata = tx_start;
      REG_TX_END:     prdata = tx_end;
      REG_TX_FORWARD: prdata = {31'd0, tx_forward};
      REG_CDS_START:  prdata = cds_start;
      REG_CDS_END:    prdata = cds_end;
      REG_EXON_COUNT: prdata = {25'd0, exon_total};
      REG_SPL_EXONIC: prdata = {24'd0, exon_reach};
      REG_SPL_INTRON: prdata = {24'd0, intron_reach};
      default:        prdata = '0;
    endcase
  end

  // Exon table: one memory of {start, end}
  logic [63:0] exon_mem [MAX_EXONS];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr;

  in_data_t in_d;
  assign in_d = s_tdata[$bits(in_data_t)-1:0];

  state_t state;
  logic [CW-1:0] cnt;      // saturated exon count
  logic [CW-1:0] idx;      // next read index
  logic          rd_vld;   // rd_data valid this cycle
  logic [CW-1:0] ridx;     // index of rd_data
  logic          issue_done;

  // Request operands
  edge_t s, e, irs, ire, lo, hi;
  logic  ib;
  edge_t ts, te, cs, ce, xr, nr;

  // Accumulated flags
  logic exon_h, cds_h, u5, u3, intron_h, spl;
  logic sss, ess, fi, fir, dr, drr, pp, ppr, intr, rg;
  edge_t min_es, max_ee;
  edge_t prev_s, prev_e;

  logic [6:0] mask_r;
  logic [7:0] feat_r, spl_r;

  assign s_tready = (state == S_IDLE);
  wire in_fire = s_tvalid && s_tready;

  // Result register takes a new result once the previous one has left
  wire out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  logic [CW-1:0] cnt_w;
  assign cnt_w = (32'(exon_total) > MAX_EXONS) ? CW'(MAX_EXONS) : CW'(exon_total);

  always_ff @(posedge clk) begin
    if (in_fire && s_tuser[0] == OP_LOAD && 32'(in_d.exon_index) < MAX_EXONS)
      exon_mem[AW'(in_d.exon_index)] <= {in_d.exon_first, in_d.exon_last};
    rd_data <= exon_mem[rd_addr];
  end
  assign rd_addr = idx[AW-1:0];

  // Per-exon evaluation of current read
  edge_t es, ee, os, oe;
  logic  ov, c_cds, c_lo, c_hi, c_spl;
  edge_t lh, rl;
  always_comb begin
    es = to_edge(rd_data[63:32]);
    ee = to_edge(rd_data[31:0]);
    ov = (e >= es) && (s <= ee);
    os = (s > es) ? s : es;
    oe = (e < ee) ? e : ee;
    c_cds = (oe >= cs) && (os <= ce);
    c_lo = (os < cs) && (os <= ((oe < cs - 1) ? oe : cs - 1));
    c_hi = (oe > ce) && (((os > ce + 1) ? os : ce + 1) <= oe);
    lh = (es + xr - 1 < ee) ? es + xr - 1 : ee;
    rl = (ee - xr + 1 > es) ? ee - xr + 1 : es;
    c_spl = ((xr > 0) && (ovl(s, e, es, lh) || ovl(s, e, rl, ee))) ||
            ((nr > 0) && (ovl(s, e, es - nr, es - 1) || ovl(s, e, ee + 1, ee + nr)));
  end

  // Gap between previous and current entry
  logic  gv;
  edge_t gs, ge;
  always_comb begin
    gv = 1'b0; gs = '0; ge = '0;
    if (prev_e < es) begin gs = prev_e + 1; ge = es - 1; gv = 1'b1; end
    else if (ee < prev_s) begin gs = ee + 1; ge = prev_s - 1; gv = 1'b1; end
    gv = gv && (gs <= ge);
  end

  // Output assembly
  logic don, acc, fifth, dreg, ppt, sreg;
  logic [7:0] feat_c;
  logic [6:0] mask_c;
  logic intron_f;
  always_comb begin
    don = tx_forward ? sss : ess;
    acc = tx_forward ? ess : sss;
    fifth = tx_forward ? fi : fir;
    dreg = (tx_forward ? dr : drr) && !fifth;
    ppt = tx_forward ? pp : ppr;
    sreg = rg && !don && !acc && !dreg && !fifth;
    feat_c = '0;
    mask_c = '0;
    intron_f = intron_h || (cnt == '0) || !exon_h ||
               (((s > ts) ? s : ts) < min_es) || (((e < te) ? e : te) > max_ee);
    if (e < ts) mask_c = tx_forward ? 7'd1 : 7'd2;
    else if (s > te) mask_c = tx_forward ? 7'd2 : 7'd1;
    else begin
      feat_c[0] = 1'b1;
      feat_c[1] = (s <= ts) && (e >= te);
      feat_c[2] = (s >= ts) && (e <= te);
      feat_c[3] = !(feat_c[1] || feat_c[2]);
      feat_c[4] = exon_h;
      feat_c[5] = exon_h;
      feat_c[6] = u5;
      feat_c[7] = u3;
      mask_c = {spl, intron_f, u5 || u3, cds_h, (cs == 0) && exon_h, 2'b00};
    end
  end

  // Sequencer: exon pass, then gap pass over adjacent pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      rd_vld <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && s_tuser[0] == OP_CLASSIFY) begin
            s <= to_edge(in_d.span_start);
            e <= to_edge(in_d.span_end);
            ib <= s_tuser[1];
            irs <= s_tuser[1] ? to_edge(in_d.span_end) + 1 : to_edge(in_d.span_start);
            ire <= to_edge(in_d.span_end);
            lo <= s_tuser[1] ? to_edge(in_d.span_end) : to_edge(in_d.span_start);
            hi <= s_tuser[1] ? to_edge(in_d.span_end) + 1 : to_edge(in_d.span_end);
            ts <= to_edge(tx_start); te <= to_edge(tx_end);
            cs <= to_edge(cds_start); ce <= to_edge(cds_end);
            xr <= edge_t'({26'd0, exon_reach});
            nr <= edge_t'({26'd0, intron_reach});
            cnt <= cnt_w;
            {exon_h, cds_h, u5, u3, intron_h, spl} <= '0;
            {sss, ess, fi, fir, dr, drr, pp, ppr, intr, rg} <= '0;
            min_es <= edge_t'(34'h0FFFFFFFF);
            max_ee <= '0;
            idx <= '0;
            rd_vld <= 1'b0;
            issue_done <= (cnt_w == '0);
            state <= (cnt_w == '0) ? S_FIN : S_EXON;
          end
        end
        S_EXON: begin
          // issue reads; the last issue leaves rd_vld low after its data
          rd_vld <= !issue_done;
          ridx <= idx;
          if (!issue_done) begin
            if (idx + 1'b1 == cnt) issue_done <= 1'b1;
            else idx <= idx + 1'b1;
          end
          if (rd_vld) begin
            if (es < min_es) min_es <= es;
            if (ee > max_ee) max_ee <= ee;
            if (ov) begin
              exon_h <= 1'b1;
              if (cs != 0) begin
                if (c_cds) cds_h <= 1'b1;
                if (c_lo) begin if (tx_forward) u5 <= 1'b1; else u3 <= 1'b1; end
                if (c_hi) begin if (tx_forward) u3 <= 1'b1; else u5 <= 1'b1; end
              end
            end
            if (c_spl) spl <= 1'b1;
            if (ridx + 1'b1 == cnt) begin
              state <= S_GAP;
              idx <= '0;
              issue_done <= 1'b0;
            end
          end
        end
        S_GAP: begin
          rd_vld <= !issue_done;
          ridx <= idx;
          if (!issue_done) begin
            if (idx + 1'b1 == cnt) issue_done <= 1'b1;
            else idx <= idx + 1'b1;
          end
          if (rd_vld) begin
            prev_s <= es; prev_e <= ee;
            if (ridx != '0 && gv) begin
              if ((e >= gs) && (s <= ge)) intron_h <= 1'b1;
              if (ovl(irs, ire, gs, gs + 1)) sss <= 1'b1;
              if (ovl(irs, ire, ge - 1, ge)) ess <= 1'b1;
              if (ovl(irs, ire, gs + 4, gs + 4)) fi <= 1'b1;
              if (ovl(irs, ire, ge - 4, ge - 4)) fir <= 1'b1;
              if (ovl(irs, ire, gs + 2, gs + 5)) dr <= 1'b1;
              if (ovl(irs, ire, ge - 5, ge - 2)) drr <= 1'b1;
              if (ovl(lo, hi, ge - 16, ge - 2)) pp <= 1'b1;
              if (ovl(lo, hi, gs + 2, gs + 16)) ppr <= 1'b1;
              if (ovl(irs, ire, gs + 2, ge - 2) ||
                  (ib && (irs == gs + 2 || ire == ge - 2))) intr <= 1'b1;
              if (ovl(irs, ire, gs + 2, gs + 7) || ovl(irs, ire, ge - 7, ge - 2) ||
                  ovl(irs, ire, gs - 3, gs - 1) || ovl(irs, ire, ge + 1, ge + 3) ||
                  (ib && (irs == gs || ire == ge || irs == gs + 2 || ire == ge - 2)))
                rg <= 1'b1;
            end
            if (ridx + 1'b1 == cnt) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            mask_r <= mask_c;
            feat_r <= feat_c;
            spl_r <= {don || acc || fifth || dreg || ppt || sreg, sreg, intr,
                      ppt, dreg, fifth, acc, don};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      m_tvalid <= out_load || (m_tvalid && !m_tready);
    end
  end

  assign m_tdata = {1'b0, spl_r, feat_r, mask_r};

endmodule

FILE: bench/span_class_checker.sv
`timescale 1ns / 100ps

module span_class_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [23:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);
  import vsrsc_pkg::*;

  localparam int TABLE_DEPTH = 64;

  typedef struct packed {
    logic [7:0] splice_flags;
    logic [7:0] feature_flags;
    logic [6:0] region_bits;
  } verdict_t;

  // shadow of the exon table and the transcript registers
  logic [31:0] exon_lo [TABLE_DEPTH];
  logic [31:0] exon_hi [TABLE_DEPTH];
  logic [31:0] tx_lo, tx_hi, cds_lo, cds_hi;
  logic        fwd_strand;
  logic [6:0]  n_exons;
  logic [7:0]  reach_exon, reach_intron;

  verdict_t verdict_q[$];
  int       n_mismatch;

  assign fail_count = n_mismatch;

  function automatic edge_t widen(input logic [31:0] v);
    return edge_t'({2'b00, v});
  endfunction

  function automatic bit hits(input edge_t s, input edge_t e, input edge_t lo, input edge_t hi);
    return (hi >= lo) && (e >= lo) && (s <= hi);
  endfunction

  function automatic edge_t emin(input edge_t a, input edge_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic edge_t emax(input edge_t a, input edge_t b);
    return (a > b) ? a : b;
  endfunction

  // intron between two table neighbours, in either order
  function automatic bit intron_between(input int a, input int b,
                                        output edge_t gs, output edge_t ge);
    edge_t as_, ae, bs, be;
    as_ = widen(exon_lo[a]); ae = widen(exon_hi[a]);
    bs = widen(exon_lo[b]); be = widen(exon_hi[b]);
    gs = 0; ge = 0;
    if (ae < bs) begin
      gs = ae + 1; ge = bs - 1;
    end else if (be < as_) begin
      gs = be + 1; ge = as_ - 1;
    end else begin
      return 0;
    end
    return gs <= ge;
  endfunction

  function automatic bit near_boundary(input edge_t s, input edge_t e,
                                       input edge_t es, input edge_t ee);
    edge_t x, n;
    x = widen({24'd0, reach_exon});
    n = widen({24'd0, reach_intron});
    if (x > 0 && (hits(s, e, es, emin(es + x - 1, ee)) || hits(s, e, emax(ee - x + 1, es), ee)))
      return 1;
    if (n > 0 && (hits(s, e, es - n, es - 1) || hits(s, e, ee + 1, ee + n)))
      return 1;
    return 0;
  endfunction

  function automatic verdict_t classify_span(input logic [31:0] s32, input logic [31:0] e32,
                                             input bit ins);
    verdict_t v;
    edge_t s, e, ts, te, cs, ce, es, ee, os, oe, gs, ge, min_es, max_ee;
    edge_t irs, ire, lo, hi;
    int    cnt;
    bit    in_exon, in_cds, u5, u3, in_intron, near_spl;
    bit    sss, ess, fi, fir, dr, drr, pp, ppr, intr, reg_hit;
    bit    don, acc, fifth, dreg, ppt, sreg;
    s = widen(s32); e = widen(e32);
    ts = widen(tx_lo); te = widen(tx_hi); cs = widen(cds_lo); ce = widen(cds_hi);
    cnt = (n_exons > TABLE_DEPTH) ? TABLE_DEPTH : int'(n_exons);
    v = '0;
    min_es = widen(32'hFFFF_FFFF);
    max_ee = 0;
    {in_exon, in_cds, u5, u3, in_intron, near_spl} = '0;

    // coarse region and feature flags
    if (e < ts) begin
      v.region_bits = fwd_strand ? 7'd1 : 7'd2;
    end else if (s > te) begin
      v.region_bits = fwd_strand ? 7'd2 : 7'd1;
    end else begin
      v.feature_flags[0] = 1'b1;
      if (s <= ts && e >= te) v.feature_flags[1] = 1'b1;
      if (s >= ts && e <= te) v.feature_flags[2] = 1'b1;
      if (!v.feature_flags[1] && !v.feature_flags[2]) v.feature_flags[3] = 1'b1;
      for (int k = 0; k < cnt; k++) begin
        es = widen(exon_lo[k]); ee = widen(exon_hi[k]);
        min_es = emin(min_es, es);
        max_ee = emax(max_ee, ee);
        if (e >= es && s <= ee) begin
          in_exon = 1;
          if (cs != 0) begin
            os = emax(s, es); oe = emin(e, ee);
            if (oe >= cs && os <= ce) in_cds = 1;
            if (os < cs && os <= emin(oe, cs - 1)) begin
              if (fwd_strand) u5 = 1; else u3 = 1;
            end
            if (oe > ce && emax(os, ce + 1) <= oe) begin
              if (fwd_strand) u3 = 1; else u5 = 1;
            end
          end
        end
        if (near_boundary(s, e, es, ee)) near_spl = 1;
      end
      for (int k = 0; k + 1 < cnt; k++)
        if (intron_between(k, k + 1, gs, ge) && e >= gs && s <= ge) in_intron = 1;
      if (cnt == 0 || !in_exon || emax(s, ts) < min_es || emin(e, te) > max_ee) in_intron = 1;
      v.feature_flags[4] = in_exon;
      v.feature_flags[5] = in_exon;
      v.feature_flags[6] = u5;
      v.feature_flags[7] = u3;
      v.region_bits[2] = (cs == 0) && in_exon;
      v.region_bits[3] = in_cds;
      v.region_bits[4] = u5 || u3;
      v.region_bits[5] = in_intron;
      v.region_bits[6] = near_spl;
    end

    // splice sites over every gap; insertions use the flanking pair
    irs = ins ? e + 1 : s;
    ire = e;
    lo = ins ? ire : s;
    hi = ins ? irs : e;
    {sss, ess, fi, fir, dr, drr, pp, ppr, intr, reg_hit} = '0;
    for (int k = 0; k + 1 < cnt; k++) begin
      if (intron_between(k, k + 1, gs, ge)) begin
        if (hits(irs, ire, gs, gs + 1)) sss = 1;
        if (hits(irs, ire, ge - 1, ge)) ess = 1;
        if (hits(irs, ire, gs + 4, gs + 4)) fi = 1;
        if (hits(irs, ire, ge - 4, ge - 4)) fir = 1;
        if (hits(irs, ire, gs + 2, gs + 5)) dr = 1;
        if (hits(irs, ire, ge - 5, ge - 2)) drr = 1;
        if (hits(lo, hi, ge - 16, ge - 2)) pp = 1;
        if (hits(lo, hi, gs + 2, gs + 16)) ppr = 1;
        if (hits(irs, ire, gs + 2, ge - 2) || (ins && (irs == gs + 2 || ire == ge - 2)))
          intr = 1;
        if (hits(irs, ire, gs + 2, gs + 7) || hits(irs, ire, ge - 7, ge - 2) ||
            hits(irs, ire, gs - 3, gs - 1) || hits(irs, ire, ge + 1, ge + 3) ||
            (ins && (irs == gs || ire == ge || irs == gs + 2 || ire == ge - 2)))
          reg_hit = 1;
      end
    end
    don = fwd_strand ? sss : ess;
    acc = fwd_strand ? ess : sss;
    fifth = fwd_strand ? fi : fir;
    dreg = (fwd_strand ? dr : drr) && !fifth;
    ppt = fwd_strand ? pp : ppr;
    sreg = reg_hit && !don && !acc && !dreg && !fifth;
    v.splice_flags = {don || acc || fifth || dreg || ppt || sreg, sreg, intr, ppt,
                      dreg, fifth, acc, don};
    return v;
  endfunction

  always @(posedge clk) begin
    in_data_t req;
    verdict_t got, want;
    if (rst) begin
      tx_lo <= '0; tx_hi <= '0; cds_lo <= '0; cds_hi <= '0;
      fwd_strand <= 1'b1; n_exons <= '0; reach_exon <= 8'd3; reach_intron <= 8'd8;
      n_mismatch <= 0;
      pending <= 0;
      verdict_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TX_START:   tx_lo <= pwdata;
          REG_TX_END:     tx_hi <= pwdata;
          REG_TX_FORWARD: fwd_strand <= pwdata[0];
          REG_CDS_START:  cds_lo <= pwdata;
          REG_CDS_END:    cds_hi <= pwdata;
          REG_EXON_COUNT: n_exons <= pwdata[6:0];
          REG_SPL_EXONIC: reach_exon <= pwdata[7:0];
          REG_SPL_INTRON: reach_intron <= pwdata[7:0];
          default: ;
        endcase
      end
      // accepted request: load the table or predict a classification
      if (s_tvalid && s_tready) begin
        req = s_tdata[$bits(in_data_t)-1:0];
        if (s_tuser[0] == OP_LOAD) begin
          exon_lo[req.exon_index] = req.exon_first;
          exon_hi[req.exon_index] = req.exon_last;
        end else begin
          verdict_q.push_back(classify_span(req.span_start, req.span_end, s_tuser[1]));
        end
      end
      // accepted result against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata[22:0];
        if (verdict_q.size() == 0) begin
          if (n_mismatch < 10) $display("%0t: unexpected result %h", $realtime, got);
          n_mismatch <= n_mismatch + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (n_mismatch < 10)
              $display("%0t: mismatch region %h/%h feature %h/%h splice %h/%h (exp/act)",
                       $realtime, want.region_bits, got.region_bits, want.feature_flags,
                       got.feature_flags, want.splice_flags, got.splice_flags);
            n_mismatch <= n_mismatch + 1;
          end
        end
      end
      pending <= verdict_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vsrsc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 140;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // tdata: exon_index, exon_first, exon_last, span_start, span_end, zero pad
  logic [135:0] s_tdata = '0;
  // tuser: operation, is_insertion
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // tdata: region_bits, feature_flags, splice_flags, zero pad
  logic [23:0]  m_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count, pending;

  logic [31:0]  lay_lo [64];
  logic [31:0]  lay_hi [64];
  int           n_lay;
  bit           hold_req = 0;
  bit           burst_send = 0;
  int           idle_cnt = 0;

  always #1 clk = ~clk;

  variant_span_region_splice_classifier i_dut (.*);

  span_class_checker i_chk (.*);

  // receiver side: random stalls, runs without stalls, one long hold-off
  initial begin : result_sink
    int gap;
    bit burst_recv;
    burst_recv = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) burst_recv = ~burst_recv;
      gap = burst_recv ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        hold_req = 0;
        gap = 400;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("variant_span_region_splice_classifier regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_req(input logic op, input logic [5:0] idx, input logic [31:0] a,
                          input logic [31:0] b, input logic [31:0] c, input logic [31:0] d,
                          input logic ins);
    int gap;
    in_data_t req;
    if ($urandom_range(0, 39) == 0) burst_send = ~burst_send;
    gap = burst_send ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.exon_index = idx; req.exon_first = a; req.exon_last = b;
    req.span_start = c; req.span_end = d;
    s_tdata <= {2'b00, req};
    s_tuser <= {ins, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic classify(input logic [31:0] s, input logic [31:0] e, input logic ins);
    send_req(OP_CLASSIFY, 6'($urandom_range(0, 63)), $urandom, $urandom, s, e, ins);
  endtask

  // wait for every result, then for the block to settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // span near an exon edge, or a wild, reversed or insertion span
  task automatic random_span();
    logic [31:0] pos, s, e;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8 || n_lay == 0) begin
      classify($urandom, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      pos = $urandom_range(0, 1) ? lay_lo[$urandom_range(0, n_lay - 1)]
                                 : lay_hi[$urandom_range(0, n_lay - 1)];
      pos = pos + $urandom_range(0, 40) - 20;
      if (r < 14) begin
        classify(pos + $urandom_range(1, 5), pos, 1'b0);
      end else if (r < 40) begin
        classify($urandom_range(0, 1) ? pos + 1 : pos, pos, 1'b1);
      end else begin
        s = pos; e = pos + $urandom_range(0, 6);
        classify(s, e, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] base, cur;
    int n_items;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: empty table, extreme and reversed spans
    classify(32'd0, 32'd0, 1'b0);
    classify(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    classify(32'd0, 32'hFFFF_FFFF, 1'b0);
    classify(32'hFFFF_FFFF, 32'd0, 1'b0);
    classify(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    classify(32'd1, 32'd0, 1'b1);
    drain();

    for (int p = 1; p <= 9; p++) begin
      n_lay = (p == 5) ? 64 : (p == 7) ? 1 : $urandom_range(1, 8);
      base = (p == 2) ? 32'd0 : (p == 4) ? 32'hFFFF_0000 : $urandom_range(100, 32'hF000_0000);
      // exon layout: real gaps, touching and overlapping neighbours
      cur = base;
      for (int k = 0; k < n_lay; k++) begin
        lay_lo[k] = cur;
        lay_hi[k] = cur + $urandom_range(0, 40);
        case ($urandom_range(0, 9))
          0: cur = lay_hi[k] - 2;
          1: cur = lay_hi[k] + 1;
          default: cur = lay_hi[k] + $urandom_range(2, 31);
        endcase
      end
      write_reg(REG_TX_START, (p == 2) ? 32'd0 : lay_lo[0] - $urandom_range(0, 50));
      write_reg(REG_TX_END, (p == 4) ? 32'hFFFF_FFFF : lay_hi[n_lay-1] + $urandom_range(0, 50));
      write_reg(REG_TX_FORWARD, 32'(p % 2));
      write_reg(REG_CDS_START, (p == 6) ? 32'd0 : lay_lo[0] + $urandom_range(0, 60));
      write_reg(REG_CDS_END, lay_hi[n_lay-1] - $urandom_range(0, 60));
      // a count above the table depth acts as the full table
      write_reg(REG_EXON_COUNT, (p == 5) ? 32'd127 : 32'(n_lay));
      write_reg(REG_SPL_EXONIC, (p == 2) ? 32'd0 : (p == 4) ? 32'd255 : $urandom_range(0, 12));
      write_reg(REG_SPL_INTRON, (p == 2) ? 32'd0 : (p == 4) ? 32'd255 : $urandom_range(0, 20));
      for (int k = 0; k < n_lay; k++)
        send_req(OP_LOAD, 6'(k), lay_lo[k], lay_hi[k], $urandom, $urandom,
                 1'($urandom_range(0, 1)));
      if (p == 3) hold_req = 1;
      n_items = (p == 5) ? 60 : 115;
      for (int i = 0; i < n_items; i++) begin
        // a few loads to slots outside the layout, with any content
        if ($urandom_range(0, 19) == 0 && n_lay < 64)
          send_req(OP_LOAD, 6'($urandom_range(n_lay, 63)), $urandom, $urandom,
                   $urandom, $urandom, 1'($urandom_range(0, 1)));
        else
          random_span();
      end
      drain();
    end

    if (fail_count == 0)
      $display("variant_span_region_splice_classifier regression: pass");
    else
      $display("variant_span_region_splice_classifier regression: fail");
    $finish;
  end

endmodule
